/* rtl/sorted_key_table_assert.svh */
// assertion macros shared by the sorted key table rtl
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define SKT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define SKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SKT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/skt_pkg.sv */
package skt_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_BITS_DEF  = 16;
    localparam int DATA_BITS_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RETRIEVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPLACE  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUR_RD,
        ST_CUR_CMP,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT,
        ST_PLACE,
        ST_DONE
    } t_state;

endpackage

/* rtl/sorted_key_table.sv */
// sorted key table: holds up to CAPACITY key/data entries in ascending key order in one
// single-port-write, registered-read memory, plus an entry count and a cursor. each input
// transaction carries a command (insert, retrieve, replace at cursor) and gives exactly one
// result transaction with status, found flag, retrieved data, cursor and count. commands run
// one at a time; a binary search step is a memory read state followed by a compare state, an
// insert of a new key moves each larger entry up one place and then writes the new entry,
// and a replace that hits the cursor entry reads it and overwrites it without a search. all
// of these steps share the memory's single read port. a new command is taken while the
// previous result still waits in the output register. no clearing pass: only entries below
// the count are ever read.
`include "sorted_key_table_assert.svh"

module sorted_key_table #(
    parameter int CAPACITY  = skt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS  = skt_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = skt_pkg::DATA_BITS_DEF,
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int POS_W    = IDX_W + 1,
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int IN_W     = ((KEY_BITS + DATA_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((DATA_BITS + POS_W + CNT_W + 7) / 8) * 8,
    localparam int OUSER_W  = skt_pkg::STATUS_W + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_W-1:0]            s_axis_tdata,  // entry_key, entry_data, zero pad
    input  logic [skt_pkg::CMD_W-1:0]  s_axis_tuser,  // cmd
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_W-1:0]           m_axis_tdata,  // data_out, position, count, zero pad
    output logic [OUSER_W-1:0]         m_axis_tuser   // status, found
);

    // search bounds need room for -1 and for the count itself
    localparam int SRCH_W = IDX_W + 2;
    localparam int ENT_W  = KEY_BITS + DATA_BITS;
    localparam logic signed [SRCH_W-1:0] S_ONE = SRCH_W'(1);

    // entry memory, key in the upper bits
    logic [ENT_W-1:0] r_entry_mem [CAPACITY];
    logic [ENT_W-1:0] r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [ENT_W-1:0] mem_wd;
    logic [IDX_W-1:0] mem_ra;

    // control state
    skt_pkg::t_state          r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [POS_W-1:0]  r_cursor, n_cursor;
    logic                     r_wr_pend, n_wr_pend;
    logic                     r_out_valid, n_out_valid;

    // working registers
    logic [skt_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [KEY_BITS-1:0]          r_key, n_key;
    logic [DATA_BITS-1:0]         r_data, n_data;
    logic signed [SRCH_W-1:0]     r_lo, n_lo;
    logic signed [SRCH_W-1:0]     r_hi, n_hi;
    logic [IDX_W-1:0]             r_mid, n_mid;
    logic signed [SRCH_W-1:0]     r_at, n_at;
    logic signed [SRCH_W-1:0]     r_j, n_j;
    logic [IDX_W-1:0]             r_wr_addr, n_wr_addr;
    logic [skt_pkg::STATUS_W-1:0] r_status, n_status;
    logic                         r_found, n_found;
    logic [DATA_BITS-1:0]         r_dout, n_dout;

    // output register
    logic [skt_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic                         r_out_found, n_out_found;
    logic [DATA_BITS-1:0]         r_out_dout, n_out_dout;
    logic signed [POS_W-1:0]      r_out_pos, n_out_pos;
    logic [CNT_W-1:0]             r_out_cnt, n_out_cnt;

    logic                   full;
    logic                   cursor_ok;
    logic signed [SRCH_W:0] mid_sum;
    logic [IDX_W-1:0]       mid;
    logic [KEY_BITS-1:0]    rd_key;
    logic [KEY_BITS-1:0]    in_key;
    logic [DATA_BITS-1:0]   in_data;
    logic signed [SRCH_W-1:0] place_at;

    assign in_key    = s_axis_tdata[KEY_BITS-1:0];
    assign in_data   = s_axis_tdata[ENT_W-1:KEY_BITS];
    assign full      = (r_count >= CNT_W'(CAPACITY));
    assign cursor_ok = !r_cursor[POS_W-1] && (CNT_W'(r_cursor[IDX_W-1:0]) < r_count);
    // midpoint; both bounds are non-negative whenever it is used
    assign mid_sum   = (SRCH_W+1)'(r_lo) + (SRCH_W+1)'(r_hi);
    assign mid       = mid_sum[IDX_W:1];
    assign rd_key    = r_rdata[ENT_W-1:DATA_BITS];
    assign place_at  = r_at + S_ONE;

    assign s_axis_tready = (r_state == skt_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_cnt, r_out_pos, r_out_dout});
    assign m_axis_tuser  = {r_out_found, r_out_status};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_entry_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_entry_mem[mem_ra];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_wr_pend    = 1'b0;
        n_out_valid  = r_out_valid;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_data       = r_data;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_at         = r_at;
        n_j          = r_j;
        n_wr_addr    = r_wr_addr;
        n_status     = r_status;
        n_found      = r_found;
        n_dout       = r_dout;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_dout   = r_out_dout;
        n_out_pos    = r_out_pos;
        n_out_cnt    = r_out_cnt;

        // shift write-back of the entry read in the previous cycle
        mem_we = r_wr_pend;
        mem_wa = r_wr_addr;
        mem_wd = r_rdata;
        mem_ra = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            skt_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd    = s_axis_tuser;
                    n_key    = in_key;
                    n_data   = in_data;
                    n_status = skt_pkg::ST_OK;
                    n_found  = 1'b0;
                    n_dout   = '0;
                    n_lo     = '0;
                    n_hi     = SRCH_W'(r_count) - S_ONE;
                    unique case (s_axis_tuser)
                        skt_pkg::CMD_INSERT: begin
                            if (full) begin
                                n_status = skt_pkg::ST_FULL;
                                n_state  = skt_pkg::ST_DONE;
                            end else begin
                                n_state = skt_pkg::ST_SRCH_RD;
                            end
                        end
                        skt_pkg::CMD_RETRIEVE: begin
                            n_state = skt_pkg::ST_SRCH_RD;
                        end
                        skt_pkg::CMD_REPLACE: begin
                            priority if (r_count == '0) begin
                                n_status = skt_pkg::ST_EMPTY;
                                n_state  = skt_pkg::ST_DONE;
                            end else if (cursor_ok) begin
                                n_state = skt_pkg::ST_CUR_RD;
                            end else if (full) begin
                                n_status = skt_pkg::ST_FULL;
                                n_state  = skt_pkg::ST_DONE;
                            end else begin
                                n_state = skt_pkg::ST_SRCH_RD;
                            end
                        end
                        default: begin
                            // unused code: report the state unchanged
                            n_state = skt_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            skt_pkg::ST_CUR_RD: begin
                mem_ra  = r_cursor[IDX_W-1:0];
                n_state = skt_pkg::ST_CUR_CMP;
            end
            skt_pkg::ST_CUR_CMP: begin
                priority if (rd_key == r_key) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_cursor[IDX_W-1:0];
                    mem_wd  = {r_key, r_data};
                    n_found = 1'b1;
                    n_state = skt_pkg::ST_DONE;
                end else if (full) begin
                    n_status = skt_pkg::ST_FULL;
                    n_state  = skt_pkg::ST_DONE;
                end else begin
                    n_state = skt_pkg::ST_SRCH_RD;
                end
            end
            skt_pkg::ST_SRCH_RD: begin
                if (r_lo <= r_hi) begin
                    mem_ra  = mid;
                    n_mid   = mid;
                    n_state = skt_pkg::ST_SRCH_CMP;
                end else begin
                    // miss: predecessor index is the upper bound
                    n_at = r_hi;
                    n_j  = SRCH_W'(r_count) - S_ONE;
                    if (r_cmd == skt_pkg::CMD_RETRIEVE) begin
                        n_status = skt_pkg::ST_MISS;
                        n_state  = skt_pkg::ST_DONE;
                    end else begin
                        n_state = skt_pkg::ST_SHIFT;
                    end
                end
            end
            skt_pkg::ST_SRCH_CMP: begin
                priority if (r_key < rd_key) begin
                    n_hi    = SRCH_W'(r_mid) - S_ONE;
                    n_state = skt_pkg::ST_SRCH_RD;
                end else if (r_key > rd_key) begin
                    n_lo    = SRCH_W'(r_mid) + S_ONE;
                    n_state = skt_pkg::ST_SRCH_RD;
                end else begin
                    n_cursor = POS_W'(r_mid);
                    n_found  = 1'b1;
                    if (r_cmd == skt_pkg::CMD_RETRIEVE) begin
                        n_dout = r_rdata[DATA_BITS-1:0];
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = r_mid;
                        mem_wd = {r_key, r_data};
                    end
                    n_state = skt_pkg::ST_DONE;
                end
            end
            skt_pkg::ST_SHIFT: begin
                // read entry j now, write it to j+1 in the next cycle
                if (r_j > r_at) begin
                    mem_ra    = r_j[IDX_W-1:0];
                    n_wr_pend = 1'b1;
                    n_wr_addr = r_j[IDX_W-1:0] + IDX_W'(1);
                    n_j       = r_j - S_ONE;
                end else begin
                    n_state = skt_pkg::ST_PLACE;
                end
            end
            skt_pkg::ST_PLACE: begin
                mem_we   = 1'b1;
                mem_wa   = place_at[IDX_W-1:0];
                mem_wd   = {r_key, r_data};
                n_cursor = place_at[POS_W-1:0];
                n_count  = r_count + CNT_W'(1);
                n_state  = skt_pkg::ST_DONE;
            end
            skt_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_dout   = r_dout;
                    n_out_pos    = r_cursor;
                    n_out_cnt    = r_count;
                    n_state      = skt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skt_pkg::ST_IDLE;
            r_count     <= '0;
            r_cursor    <= '1;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_data       <= n_data;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_at         <= n_at;
        r_j          <= n_j;
        r_wr_addr    <= n_wr_addr;
        r_status     <= n_status;
        r_found      <= n_found;
        r_dout       <= n_dout;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_dout   <= n_out_dout;
        r_out_pos    <= n_out_pos;
        r_out_cnt    <= n_out_cnt;
    end

    // count never passes capacity
    `SKT_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY), "count above capacity")
    // cursor is either none or inside the stored entries
    `SKT_ASSERT(a_cursor_range, i_clk, i_rst_n, (r_cursor[POS_W-1] && (&r_cursor)) || (!r_cursor[POS_W-1] && (CNT_W'(r_cursor[IDX_W-1:0]) < r_count)), "cursor outside stored entries")
    // no shift write-back may be left over when a new command can enter
    `SKT_ASSERT(a_idle_no_pend, i_clk, i_rst_n, !(r_state == skt_pkg::ST_IDLE) || !r_wr_pend, "shift write pending in idle")
    // an accepted transaction always leaves idle
    `SKT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state != skt_pkg::ST_IDLE, "accepted transaction not started")

endmodule

/* tb/tb.sv */
module tb;

    localparam int TABLE_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 400;
    localparam int FULL_ITEMS   = 40;     // commands to run once the table has filled
    localparam int MAX_ITEMS    = 1000;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;

    // the fourth command code is not used by the block and must be ignored
    localparam logic [skt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [skt_pkg::STATUS_W-1:0] status;
        logic                         found;
        logic [31:0]                  data_out;
        logic [6:0]                   position;
        logic [6:0]                   count;
    } t_table_result;

    // keeps a copy of the sorted table, works out each command's result and checks the block
    class key_table_checker;
        logic [15:0]   keys [TABLE_DEPTH];
        logic [31:0]   vals [TABLE_DEPTH];
        int            count;
        int            cursor;
        t_table_result expected_results [$];
        int            errors;
        int            n_results;
        int            peak_count;
        int            hits;
        int            cmd_seen [4];
        int            status_seen [4];

        function new();
            count      = 0;
            cursor     = -1;
            errors     = 0;
            n_results  = 0;
            peak_count = 0;
            hits       = 0;
            foreach (cmd_seen[i]) cmd_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // binary search; on a miss gives the index of the largest smaller key, or -1
        function bit find_key(input logic [15:0] key, output int where);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = count - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (key < keys[mid]) begin
                    hi = mid - 1;
                end else if (key > keys[mid]) begin
                    lo = mid + 1;
                end else begin
                    where = mid;
                    return 1'b1;
                end
            end
            where = hi;
            return 1'b0;
        endfunction

        // overwrite an equal key or open a slot in order; refused on a full table
        function logic [skt_pkg::STATUS_W-1:0] place_entry(input logic [15:0] key,
                                                           input logic [31:0] data,
                                                           output logic hit);
            int at;
            int j;
            hit = 1'b0;
            if (count >= TABLE_DEPTH) return skt_pkg::ST_FULL;
            if (find_key(key, at)) begin
                vals[at] = data;
                cursor   = at;
                hit      = 1'b1;
                return skt_pkg::ST_OK;
            end
            for (j = count - 1; j > at; j--) begin
                keys[j + 1] = keys[j];
                vals[j + 1] = vals[j];
            end
            at++;
            keys[at] = key;
            vals[at] = data;
            cursor   = at;
            count++;
            return skt_pkg::ST_OK;
        endfunction

        function logic [15:0] cursor_key();
            if (cursor >= 0 && cursor < count) return keys[cursor];
            return 16'h0000;
        endfunction

        // called for every accepted command transaction
        function void take_command(input logic [skt_pkg::CMD_W-1:0] cmd,
                                   input logic [15:0] key, input logic [31:0] data);
            t_table_result res;
            int            at;
            logic          hit;
            res = '0;
            res.status = skt_pkg::ST_OK;
            case (cmd)
                skt_pkg::CMD_INSERT: begin
                    res.status = place_entry(key, data, hit);
                    res.found  = hit;
                end
                skt_pkg::CMD_RETRIEVE: begin
                    if (find_key(key, at)) begin
                        cursor       = at;
                        res.data_out = vals[at];
                        res.found    = 1'b1;
                    end else begin
                        res.status = skt_pkg::ST_MISS;
                    end
                end
                skt_pkg::CMD_REPLACE: begin
                    if (count == 0) begin
                        res.status = skt_pkg::ST_EMPTY;
                    end else if (cursor >= 0 && cursor < count && keys[cursor] == key) begin
                        vals[cursor] = data;
                        res.found    = 1'b1;
                    end else begin
                        res.status = place_entry(key, data, hit);
                        res.found  = hit;
                    end
                end
                default: ;
            endcase
            res.position = cursor[6:0];
            res.count    = count[6:0];
            expected_results.push_back(res);
            cmd_seen[cmd]++;
            status_seen[res.status]++;
            if (res.found) hits++;
            if (count > peak_count) peak_count = count;
        endfunction

        task report(input string msg);
            $display("mismatch at result %0d: %s", n_results, msg);
            errors++;
        endtask

        // called for every accepted result transaction
        task check_result(input t_table_result got);
            t_table_result want;
            if (expected_results.size() == 0) begin
                report("result with no command waiting");
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, expected %0d", got.status, want.status));
                if (got.found !== want.found)
                    report($sformatf("found %0b, expected %0b", got.found, want.found));
                if (got.data_out !== want.data_out)
                    report($sformatf("data_out 0x%08h, expected 0x%08h",
                                     got.data_out, want.data_out));
                if (got.position !== want.position)
                    report($sformatf("position %0d, expected %0d",
                                     $signed(got.position), $signed(want.position)));
                if (got.count !== want.count)
                    report($sformatf("count %0d, expected %0d", got.count, want.count));
            end
            n_results++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;       // entry_key, entry_data
    logic [1:0]  s_axis_tuser = '0;       // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;            // data_out, position, count, zero pad
    logic [2:0]  m_axis_tuser;            // status, found

    key_table_checker table_check;
    logic [15:0]      key_pool [$];
    int               idle_pct = 0;
    int               stall_pct = 0;
    int               cycles = 0;

    always #2 i_clk = ~i_clk;

    sorted_key_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            table_check.check_result('{status:   m_axis_tuser[1:0],
                                       found:    m_axis_tuser[2],
                                       data_out: m_axis_tdata[31:0],
                                       position: m_axis_tdata[38:32],
                                       count:    m_axis_tdata[45:39]});
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // offer one command transaction, with random gaps ahead of it, and wait for acceptance
    task automatic send_command(input logic [skt_pkg::CMD_W-1:0] cmd,
                                input logic [15:0] key, input logic [31:0] data);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {data, key};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        table_check.take_command(cmd, key, data);
        if (cmd == skt_pkg::CMD_INSERT || cmd == skt_pkg::CMD_REPLACE) key_pool.push_back(key);
    endtask

    initial begin
        int                        idle_by_phase [4];
        int                        stall_by_phase [4];
        int                        n;
        int                        full_items;
        int                        pick;
        logic [skt_pkg::CMD_W-1:0] cmd;
        logic [15:0]               key;
        logic [31:0]               data;

        idle_by_phase  = '{0, 88, 0, 14};
        stall_by_phase = '{0, 0, 88, 14};
        table_check = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: replace refused, retrieve misses, unused code ignored
        send_command(skt_pkg::CMD_REPLACE,  16'h1234, 32'h0BAD_F00D);
        send_command(skt_pkg::CMD_RETRIEVE, 16'h1234, 32'hFFFF_FFFF);
        send_command(CMD_UNUSED,            16'h0000, 32'h0000_0000);
        // first entry, then below it, above it and between
        send_command(skt_pkg::CMD_INSERT,   16'h8000, 32'hFFFF_FFFF);
        send_command(skt_pkg::CMD_INSERT,   16'h0000, 32'h0000_0000);
        send_command(skt_pkg::CMD_INSERT,   16'hFFFF, 32'hA5A5_A5A5);
        send_command(skt_pkg::CMD_INSERT,   16'h5555, 32'h5A5A_5A5A);
        send_command(skt_pkg::CMD_INSERT,   16'hAAAA, 32'h1234_5678);
        // insert of a present key overwrites its data
        send_command(skt_pkg::CMD_INSERT,   16'h8000, 32'h0000_0000);
        // hits at the middle and both ends, a miss leaves the cursor
        send_command(skt_pkg::CMD_RETRIEVE, 16'h5555, 32'h0000_0000);
        send_command(skt_pkg::CMD_RETRIEVE, 16'h5556, 32'h0000_0000);
        send_command(skt_pkg::CMD_RETRIEVE, 16'h0000, 32'hFFFF_FFFF);
        send_command(skt_pkg::CMD_RETRIEVE, 16'hFFFF, 32'h0000_0000);
        send_command(skt_pkg::CMD_RETRIEVE, 16'h8000, 32'h0000_0000);
        // replace at the cursor, replace of a new key, replace of another present key
        send_command(skt_pkg::CMD_REPLACE,  16'h8000, 32'hFFFF_FFFF);
        send_command(skt_pkg::CMD_REPLACE,  16'h1234, 32'hC0DE_CAFE);
        send_command(skt_pkg::CMD_REPLACE,  16'h5555, 32'h0F0F_0F0F);
        send_command(CMD_UNUSED,            16'hFFFF, 32'hFFFF_FFFF);
        send_command(skt_pkg::CMD_RETRIEVE, 16'h1234, 32'h0000_0000);
        send_command(skt_pkg::CMD_RETRIEVE, 16'h8000, 32'h0000_0000);

        // random part: phases of idling and of receiver stalls every hundred commands; it runs on,
        // up to MAX_ITEMS, until the table has filled and some commands have been seen against a full table
        n = 0;
        full_items = 0;
        while ((n < RANDOM_ITEMS || full_items < FULL_ITEMS) && n < MAX_ITEMS) begin
            idle_pct  = idle_by_phase[(n / 100) % 4];
            stall_pct = stall_by_phase[(n / 100) % 4];
            pick = $urandom_range(99);
            data = $urandom;
            key  = key_pool[$urandom_range(key_pool.size() - 1)];
            if (pick < 38) begin
                cmd = skt_pkg::CMD_INSERT;
                if ($urandom_range(1) == 0) key = 16'($urandom);
            end else if (pick < 70) begin
                cmd = skt_pkg::CMD_RETRIEVE;
                pick = $urandom_range(99);
                if (pick < 15) key = 16'($urandom);
                else if (pick < 30) key = key + 16'd1;  // lands between neighbours
            end else if (pick < 95) begin
                cmd = skt_pkg::CMD_REPLACE;
                pick = $urandom_range(99);
                if (pick < 50) key = table_check.cursor_key();
                else if (pick < 75) key = 16'($urandom);
            end else begin
                cmd = CMD_UNUSED;
                key = 16'($urandom);
            end
            send_command(cmd, key, data);
            if (table_check.count == TABLE_DEPTH) full_items++;
            n++;
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow for anything late or extra
        while (table_check.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d commands: %0d insert, %0d retrieve, %0d replace, %0d unused code",
                 n + 20, table_check.cmd_seen[skt_pkg::CMD_INSERT],
                 table_check.cmd_seen[skt_pkg::CMD_RETRIEVE],
                 table_check.cmd_seen[skt_pkg::CMD_REPLACE], table_check.cmd_seen[CMD_UNUSED]);
        $display("status ok/miss/full/empty %0d/%0d/%0d/%0d, %0d key hits, peak of %0d entries",
                 table_check.status_seen[skt_pkg::ST_OK],
                 table_check.status_seen[skt_pkg::ST_MISS],
                 table_check.status_seen[skt_pkg::ST_FULL],
                 table_check.status_seen[skt_pkg::ST_EMPTY],
                 table_check.hits, table_check.peak_count);
        if (table_check.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
